>>> src/lpcg_pkg.sv
// lpcg_pkg: sizes and the sequencer state type for the leaf pair component grouper
// no dependencies; used by leaf_pair_component_grouper
`timescale 1ns / 1ps

package lpcg_pkg;

  localparam int LEAVES     = 64;
  localparam int MAX_GROUPS = 32;

  localparam int LEAF_W = 6;
  localparam int MASK_W = 64;
  localparam int NUM_W  = 5;
  localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int IDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_EMIT
  } st_t;

endpackage

>>> src/leaf_pair_component_grouper.sv
// leaf_pair_component_grouper: groups leaves into disjoint bitmask sets, one pair per item
// depends on lpcg_pkg (sizes, sequencer state type)
`timescale 1ns / 1ps

// Each input item carries a leaf pair, a pair flag and a last flag. The groups live in one
// 32 x 64 synchronous RAM with a registered read, and a single sequencer walks it. A valid
// pair is scanned against the stored groups, one RAM read per cycle, with the hit check
// registered behind the read and a closing step at the end of the scan. A pair that
// joins two groups stops the scan there and, unless the second hit is the tail group,
// moves the tail group into the freed slot with a read step and a write step. A pair with
// no valid flag or an out-of-range leaf is not scanned. On a last item the groups are read
// back in list order, one per cycle when the output is not stalled, and the list is
// cleared. in_stall is high whenever the sequencer is busy. Results leave through an output
// register, so the next item can be taken while the final result still waits.
module leaf_pair_component_grouper (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lpcg_pkg::LEAF_W-1:0] left_leaf,
  input  logic [lpcg_pkg::LEAF_W-1:0] right_leaf,
  input  logic                       pair_valid,
  input  logic                       last_constraint,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lpcg_pkg::MASK_W-1:0] set_mask,
  output logic [lpcg_pkg::NUM_W-1:0]  set_number,
  output logic                       last_set
);

  localparam int CW = lpcg_pkg::CNT_W;
  localparam int IW = lpcg_pkg::IDX_W;
  localparam int MW = lpcg_pkg::MASK_W;
  localparam int LW = lpcg_pkg::LEAF_W;

  // group RAM
  logic [MW-1:0] mem [lpcg_pkg::MAX_GROUPS];
  logic [MW-1:0] rdata;
  logic          re;
  logic [IW-1:0] ra;
  logic          we;
  logic [IW-1:0] wa;
  logic [MW-1:0] wd;

  lpcg_pkg::st_t state;
  lpcg_pkg::st_t state_next;

  // latched item
  logic [MW-1:0] pair_bits;
  logic          last_item;

  // list length
  logic [CW-1:0] count;

  // scan pipeline: rd_idx is the address being read, chk_idx the entry in rdata
  logic [CW-1:0] rd_idx;
  logic          chk_valid;
  logic [CW-1:0] chk_idx;
  logic          found;
  logic [IW-1:0] first;
  logic [MW-1:0] acc;     // current contents of the first matching group
  logic [IW-1:0] hole;    // slot freed by a merge

  // read-out pipeline
  logic [CW-1:0] em_idx;
  logic          em_pend;
  logic [CW-1:0] em_pidx;

  logic          accept;
  logic          pair_in_ok;
  logic          hit;
  logic          merge;
  logic          scan_done;
  logic          scan_rd;
  logic          room;
  logic          take_out;
  logic          load;
  logic          em_issue;
  logic          emit_done;
  lpcg_pkg::st_t finish_st;

  assign accept = in_valid && !in_stall;

  // leaf range check, one bit wider so that LEAVES itself fits
  assign pair_in_ok = pair_valid
                    && ({1'b0, left_leaf}  < (LW + 1)'(lpcg_pkg::LEAVES))
                    && ({1'b0, right_leaf} < (LW + 1)'(lpcg_pkg::LEAVES));

  assign hit       = chk_valid && ((rdata & pair_bits) != '0);
  assign merge     = (state == lpcg_pkg::ST_SCAN) && hit && found;
  assign scan_done = (state == lpcg_pkg::ST_SCAN) && !chk_valid && (rd_idx >= count);
  assign scan_rd   = (state == lpcg_pkg::ST_SCAN) && (rd_idx < count) && !merge;
  assign room      = count < CW'(lpcg_pkg::MAX_GROUPS);

  assign take_out  = !out_valid || !out_stall;
  assign load      = (state == lpcg_pkg::ST_EMIT) && em_pend && take_out;
  assign em_issue  = (state == lpcg_pkg::ST_EMIT) && (em_idx < count) && (!em_pend || load);
  assign emit_done = (state == lpcg_pkg::ST_EMIT) && (em_idx >= count) && !em_pend;

  assign finish_st = last_item ? lpcg_pkg::ST_EMIT : lpcg_pkg::ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lpcg_pkg::ST_IDLE: begin
        if (accept) begin
          if (pair_in_ok) begin
            state_next = lpcg_pkg::ST_SCAN;
          end else if (last_constraint) begin
            state_next = lpcg_pkg::ST_EMIT;
          end
        end
      end
      lpcg_pkg::ST_SCAN: begin
        if (merge) begin
          // the tail group only moves when the second hit is not the tail itself
          if (chk_idx != (count - CW'(1))) begin
            state_next = lpcg_pkg::ST_MOVE_RD;
          end else begin
            state_next = finish_st;
          end
        end else if (scan_done) begin
          state_next = finish_st;
        end
      end
      lpcg_pkg::ST_MOVE_RD: state_next = lpcg_pkg::ST_MOVE_WR;
      lpcg_pkg::ST_MOVE_WR: state_next = finish_st;
      lpcg_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_next = lpcg_pkg::ST_IDLE;
        end
      end
      default: state_next = lpcg_pkg::ST_IDLE;
    endcase
  end

  // RAM port control and handshake
  always_comb begin
    re       = 1'b0;
    ra       = '0;
    we       = 1'b0;
    wa       = '0;
    wd       = rdata;
    in_stall = (state != lpcg_pkg::ST_IDLE);
    case (state)
      lpcg_pkg::ST_SCAN: begin
        re = scan_rd;
        ra = rd_idx[IW-1:0];
        if (hit && !found) begin
          // first match: both leaves join it
          we = 1'b1;
          wa = chk_idx[IW-1:0];
          wd = rdata | pair_bits;
        end else if (merge) begin
          // second match: fold it into the first group
          we = 1'b1;
          wa = first;
          wd = acc | rdata;
        end else if (scan_done && !found && room) begin
          // no match: append a new group
          we = 1'b1;
          wa = count[IW-1:0];
          wd = pair_bits;
        end
      end
      lpcg_pkg::ST_MOVE_RD: begin
        // count already holds the old tail index
        re = 1'b1;
        ra = count[IW-1:0];
      end
      lpcg_pkg::ST_MOVE_WR: begin
        we = 1'b1;
        wa = hole;
        wd = rdata;
      end
      lpcg_pkg::ST_EMIT: begin
        re = em_issue;
        ra = em_idx[IW-1:0];
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // group RAM, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpcg_pkg::ST_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
      em_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        pair_bits <= (MW'(1) << left_leaf) | (MW'(1) << right_leaf);
        last_item <= last_constraint;
        rd_idx    <= '0;
        chk_valid <= 1'b0;
        found     <= 1'b0;
        em_idx    <= '0;
        em_pend   <= 1'b0;
      end

      if (state == lpcg_pkg::ST_SCAN) begin
        chk_valid <= scan_rd;
        chk_idx   <= rd_idx;
        if (scan_rd) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (hit && !found) begin
          found <= 1'b1;
          first <= chk_idx[IW-1:0];
          acc   <= rdata | pair_bits;
        end
        if (merge) begin
          count <= count - CW'(1);
          hole  <= chk_idx[IW-1:0];
        end else if (scan_done && !found && room) begin
          count <= count + CW'(1);
        end
      end

      if (em_issue) begin
        em_idx  <= em_idx + CW'(1);
        em_pidx <= em_idx;
        em_pend <= 1'b1;
      end else if (load) begin
        em_pend <= 1'b0;
      end
      if (emit_done) begin
        count <= '0;
      end

      // output register
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      set_mask   <= rdata;
      set_number <= lpcg_pkg::NUM_W'(em_pidx);
      last_set   <= (em_pidx == (count - CW'(1)));
    end
  end

`ifndef SYNTH
  // the list never grows past its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(lpcg_pkg::MAX_GROUPS))
    else $error("group count above capacity");

  // the sequencer never reads and writes the same RAM entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(we && re && (wa == ra)))
    else $error("read and write of the same group entry");

  // read-out leaves the store untouched
  a_emit_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == lpcg_pkg::ST_EMIT) |-> !we)
    else $error("group store written during read-out");

  // the input is held off while a merge moves the tail group
  a_move_stall: assert property (@(posedge clk) disable iff (rst)
    (state == lpcg_pkg::ST_MOVE_RD) |=> (state == lpcg_pkg::ST_MOVE_WR) && in_stall)
    else $error("tail move interrupted");
`endif

endmodule

>>> tb/leaf_pair_component_grouper_checker.sv
// leaf_pair_component_grouper_checker: watches both channels, predicts the emitted groups
// depends on lpcg_pkg (sizes); instantiated next to the block by leaf_pair_component_grouper_tb
`timescale 1ns / 1ps

module leaf_pair_component_grouper_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [lpcg_pkg::LEAF_W-1:0] left_leaf,
  input  logic [lpcg_pkg::LEAF_W-1:0] right_leaf,
  input  logic                        pair_valid,
  input  logic                        last_constraint,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [lpcg_pkg::MASK_W-1:0] set_mask,
  input  logic [lpcg_pkg::NUM_W-1:0]  set_number,
  input  logic                        last_set,
  output int                          mismatches,
  output int                          groups_owed
);

  typedef struct {
    logic [lpcg_pkg::MASK_W-1:0] mask;
    logic [lpcg_pkg::NUM_W-1:0]  num;
    logic                        fin;
  } group_rec_t;

  logic [lpcg_pkg::MASK_W-1:0] grp_mask [lpcg_pkg::MAX_GROUPS];
  int                          grp_count;
  group_rec_t                  owed_groups [$];

  // fold one leaf pair into the group list
  function automatic void join_pair(logic [lpcg_pkg::LEAF_W-1:0] a,
                                    logic [lpcg_pkg::LEAF_W-1:0] b);
    logic [lpcg_pkg::MASK_W-1:0] bits;
    bit                          hit;
    int                          first;
    if (a >= lpcg_pkg::LEAVES || b >= lpcg_pkg::LEAVES)
      return;
    bits  = (lpcg_pkg::MASK_W'(1) << a) | (lpcg_pkg::MASK_W'(1) << b);
    hit   = 0;
    first = 0;
    for (int i = 0; i < grp_count; i++) begin
      if ((grp_mask[i] & bits) != '0) begin
        if (hit) begin
          grp_mask[first] |= grp_mask[i];
          if (i != grp_count - 1)
            grp_mask[i] = grp_mask[grp_count - 1];
          grp_count--;
          return;
        end
        grp_mask[i] |= bits;
        first = i;
        hit   = 1;
      end
    end
    if (!hit && grp_count < lpcg_pkg::MAX_GROUPS) begin
      grp_mask[grp_count] = bits;
      grp_count++;
    end
  endfunction

  // queue every stored group in list order, then clear the list
  function automatic void emit_groups();
    group_rec_t rec;
    for (int k = 0; k < grp_count; k++) begin
      rec.mask = grp_mask[k];
      rec.num  = lpcg_pkg::NUM_W'(k);
      rec.fin  = (k == grp_count - 1);
      owed_groups.insert(owed_groups.size(), rec);
    end
    grp_count = 0;
  endfunction

  initial begin
    mismatches  = 0;
    groups_owed = 0;
    grp_count   = 0;
  end

  always @(posedge clk) begin
    group_rec_t want;
    if (rst) begin
      grp_count = 0;
      owed_groups.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_groups.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected group mask=%h number=%0d last=%0b",
                   $time, set_mask, set_number, last_set);
        end else begin
          want = owed_groups.pop_front();
          if (set_mask !== want.mask) begin
            mismatches++;
            $display("%0t: set_mask expected %h actual %h", $time, want.mask, set_mask);
          end
          if (set_number !== want.num) begin
            mismatches++;
            $display("%0t: set_number expected %0d actual %0d", $time, want.num, set_number);
          end
          if (last_set !== want.fin) begin
            mismatches++;
            $display("%0t: last_set expected %0b actual %0b", $time, want.fin, last_set);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (pair_valid)
          join_pair(left_leaf, right_leaf);
        if (last_constraint)
          emit_groups();
      end
    end
    groups_owed = owed_groups.size();
  end

endmodule

>>> tb/leaf_pair_component_grouper_tb.sv
// leaf_pair_component_grouper_tb: drives leaf pairs into the grouper and gives the verdict
// depends on lpcg_pkg, leaf_pair_component_grouper and leaf_pair_component_grouper_checker
`timescale 1ns / 1ps

module leaf_pair_component_grouper_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 95;
  localparam int IDLE_PCT = 19;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [lpcg_pkg::LEAF_W-1:0] left_leaf;
  logic [lpcg_pkg::LEAF_W-1:0] right_leaf;
  logic                        pair_valid;
  logic                        last_constraint;
  logic                        out_valid;
  logic                        out_stall;
  logic [lpcg_pkg::MASK_W-1:0] set_mask;
  logic [lpcg_pkg::NUM_W-1:0]  set_number;
  logic                        last_set;

  int mismatches;
  int groups_owed;
  int cycles;
  int items_sent;  // items that carry a pair or a flush
  bit idle_en;     // random idling on both channels

  leaf_pair_component_grouper u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .left_leaf       (left_leaf),
    .right_leaf      (right_leaf),
    .pair_valid      (pair_valid),
    .last_constraint (last_constraint),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .set_mask        (set_mask),
    .set_number      (set_number),
    .last_set        (last_set)
  );

  leaf_pair_component_grouper_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .left_leaf       (left_leaf),
    .right_leaf      (right_leaf),
    .pair_valid      (pair_valid),
    .last_constraint (last_constraint),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .set_mask        (set_mask),
    .set_number      (set_number),
    .last_set        (last_set),
    .mismatches      (mismatches),
    .groups_owed     (groups_owed)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // runaway guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver back-pressure, one decision per cycle
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // offer one item and hold it until the block takes it
  task automatic send_item(input int a, input int b, input bit pv, input bit lc);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    left_leaf       <= lpcg_pkg::LEAF_W'(a);
    right_leaf      <= lpcg_pkg::LEAF_W'(b);
    pair_valid      <= pv;
    last_constraint <= lc;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (pv || lc)
      items_sent++;
  endtask

  // fill the list with single-leaf groups, overflow it once, then flush
  task automatic fill_job();
    int perm [lpcg_pkg::LEAVES];
    int j;
    int tmp;
    for (int i = 0; i < lpcg_pkg::LEAVES; i++)
      perm[i] = i;
    for (int i = lpcg_pkg::LEAVES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int k = 0; k < lpcg_pkg::MAX_GROUPS; k++)
      send_item(perm[k], perm[k], 1'b1, 1'b0);
    // list full: this pair needs a new group and must be dropped
    send_item(perm[lpcg_pkg::MAX_GROUPS], perm[lpcg_pkg::MAX_GROUPS + 1], 1'b1, 1'b0);
    send_item(perm[$urandom_range(0, lpcg_pkg::MAX_GROUPS - 1)],
              perm[$urandom_range(0, lpcg_pkg::LEAVES - 1)],
              $urandom_range(0, 1), 1'b1);
  endtask

  // a run of pairs drawn from a leaf window, so groups collide and merge
  task automatic pair_job();
    int n;
    int span;
    int lo;
    case ($urandom_range(0, 3))
      0:       span = 4;
      1:       span = 8;
      2:       span = 16;
      default: span = lpcg_pkg::LEAVES;
    endcase
    lo = $urandom_range(0, lpcg_pkg::LEAVES - span);
    n  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 8)
        // noise: neither pair nor flush
        send_item($urandom_range(0, lpcg_pkg::LEAVES - 1),
                  $urandom_range(0, lpcg_pkg::LEAVES - 1), 1'b0, 1'b0);
      else
        send_item(lo + $urandom_range(0, span - 1), lo + $urandom_range(0, span - 1),
                  1'b1, 1'b0);
    end
    send_item(lo + $urandom_range(0, span - 1), lo + $urandom_range(0, span - 1),
              $urandom_range(0, 1), 1'b1);
  endtask

  initial begin
    int target;
    int job;
    rst             = 1'b1;
    in_valid        = 1'b0;
    left_leaf       = '0;
    right_leaf      = '0;
    pair_valid      = 1'b0;
    last_constraint = 1'b0;
    out_stall       = 1'b0;
    idle_en         = 1'b1;
    items_sent      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty flush, ignored item, same leaf, merges with and without a tail move
    send_item(0, 0, 1'b0, 1'b1);     // empty flush, no groups out
    send_item(63, 63, 1'b0, 1'b0);   // neither pair nor flush
    send_item(0, 63, 1'b1, 1'b0);    // new group {0,63}
    send_item(5, 5, 1'b1, 1'b0);     // same leaf twice, group {5}
    send_item(63, 5, 1'b1, 1'b0);    // joins both groups, tail is the merged one
    send_item(10, 11, 1'b1, 1'b0);
    send_item(20, 21, 1'b1, 1'b0);
    send_item(30, 31, 1'b1, 1'b0);
    send_item(11, 30, 1'b1, 1'b0);   // merge with the tail group
    send_item(40, 41, 1'b1, 1'b0);
    send_item(0, 20, 1'b1, 1'b0);    // merge, tail group moves into the freed slot
    send_item(42, 42, 1'b0, 1'b1);   // flush only
    send_item(7, 8, 1'b1, 1'b1);     // pair applied then flushed
    send_item(62, 1, 1'b1, 1'b1);    // back-to-back flush
    send_item(33, 34, 1'b1, 1'b0);   // extend into the random part with a stored group

    // random jobs, the first one fills the list; a stretch in the middle has no idling
    target = items_sent + RANDOM_ITEMS;
    job    = 0;
    while (items_sent < target) begin
      idle_en = !(items_sent > target - 80 && items_sent < target - 40);
      if (job == 0 || $urandom_range(0, 99) < 8)
        fill_job();
      else
        pair_job();
      job++;
    end
    idle_en = 1'b1;

    @(negedge clk);
    in_valid <= 1'b0;
    while (groups_owed != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (2 * lpcg_pkg::MAX_GROUPS + 8) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
